[hw/rtl/i2c_master_bit_engine_defines.svh]
// Assertion macros shared by the checker.
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CBE_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("i2cbe assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define I2CBE_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("i2cbe assertion failed");

`endif

[hw/rtl/i2cbe_pkg.sv]
`timescale 1ns / 1ps

package i2cbe_pkg;

  localparam int unsigned HoldW = 8;
  localparam int unsigned ByteW = 8;
  localparam logic [3:0] BitsPerByte = 4'd8;
  localparam logic [HoldW-1:0] ShortHold = 8'd1;
  localparam logic [HoldW-1:0] LowHoldReset = 8'd6;
  localparam logic [HoldW-1:0] HighHoldReset = 8'd4;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ST_REL = 4'd1,
    PH_ST_SDA = 4'd2,
    PH_W_LOW  = 4'd3,
    PH_W_DATA = 4'd4,
    PH_W_HIGH = 4'd5,
    PH_A_LOW  = 4'd6,
    PH_A_REL  = 4'd7,
    PH_A_HIGH = 4'd8,
    PH_R_LOW  = 4'd9,
    PH_R_HIGH = 4'd10,
    PH_K_LOW  = 4'd11,
    PH_K_HIGH = 4'd12,
    PH_P_LOW  = 4'd13,
    PH_P_SDA  = 4'd14,
    PH_P_HIGH = 4'd15
  } phase_e;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_STOP  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_START    = 3'd1,
    OP_WRITE    = 3'd2,
    OP_READ     = 3'd3,
    OP_STOP     = 3'd4,
    OP_READ_ACK = 3'd5
  } op_e;

  typedef enum logic {
    CFG_LOW_HOLD  = 1'b0,
    CFG_HIGH_HOLD = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    phase_e           phase;
    logic [3:0]       bit_left;
    logic [ByteW-1:0] shift_byte;
    op_e              active_op;
    logic [HoldW-1:0] hold_left;
    logic             scl_drive;
    logic             sda_drive;
    logic             ack_flag;
    logic [ByteW-1:0] last_read;
  } eng_state_t;

  typedef struct packed {
    logic done;
    logic rejected;
  } step_flags_t;

endpackage

[hw/rtl/i2cbe_step.sv]
`timescale 1ns / 1ps

module i2cbe_step (
  input  i2cbe_pkg::eng_state_t  cur_i,
  input  logic [7:0]             low_hold_i,
  input  logic [7:0]             high_hold_i,
  input  logic [2:0]             command_i,
  input  logic [6:0]             address_i,
  input  logic                   read_write_i,
  input  logic [7:0]             write_data_i,
  input  logic                   send_ack_i,
  input  logic                   sda_in_i,
  output i2cbe_pkg::eng_state_t  nxt_o,
  output i2cbe_pkg::step_flags_t flags_o
);
  import i2cbe_pkg::*;

  logic [HoldW-1:0] lo;
  logic [HoldW-1:0] hi;

  assign lo = (low_hold_i == '0) ? ShortHold : low_hold_i;
  assign hi = (high_hold_i == '0) ? ShortHold : high_hold_i;

  function automatic eng_state_t enter(eng_state_t s, phase_e p,
                                       logic [HoldW-1:0] l, logic [HoldW-1:0] h);
    eng_state_t r;
    r = s;
    r.phase = p;
    unique case (p)
      PH_ST_REL: begin r.scl_drive = 1'b1; r.sda_drive = 1'b1; r.hold_left = h; end
      PH_ST_SDA: begin r.sda_drive = 1'b0; r.hold_left = h; end
      PH_W_LOW:  begin r.scl_drive = 1'b0; r.sda_drive = 1'b0; r.hold_left = l; end
      PH_W_DATA: begin r.sda_drive = s.shift_byte[ByteW-1]; r.hold_left = ShortHold; end
      PH_W_HIGH: begin r.scl_drive = 1'b1; r.hold_left = h; end
      PH_A_LOW:  begin r.scl_drive = 1'b0; r.hold_left = l; end
      PH_A_REL:  begin r.sda_drive = 1'b1; r.hold_left = ShortHold; end
      PH_A_HIGH: begin r.scl_drive = 1'b1; r.hold_left = h; end
      PH_R_LOW:  begin r.scl_drive = 1'b0; r.sda_drive = 1'b1; r.hold_left = l; end
      PH_R_HIGH: begin r.scl_drive = 1'b1; r.hold_left = h; end
      PH_K_LOW: begin
        r.scl_drive = 1'b0;
        r.sda_drive = (s.active_op == OP_READ_ACK) ? 1'b0 : 1'b1;
        r.hold_left = l;
      end
      PH_K_HIGH: begin r.scl_drive = 1'b1; r.hold_left = h; end
      PH_P_LOW:  begin r.scl_drive = 1'b0; r.hold_left = l; end
      PH_P_SDA:  begin r.sda_drive = 1'b0; r.hold_left = ShortHold; end
      PH_P_HIGH: begin r.scl_drive = 1'b1; r.hold_left = ShortHold; end
      PH_IDLE:   begin r.hold_left = '0; end
    endcase
    return r;
  endfunction

  function automatic eng_state_t finish(eng_state_t s);
    eng_state_t r;
    r = s;
    r.phase = PH_IDLE;
    r.active_op = OP_NONE;
    r.hold_left = '0;
    return r;
  endfunction

  always_comb begin
    eng_state_t n;
    logic [3:0] bl;
    logic [ByteW-1:0] sb;
    n = cur_i;
    flags_o = '0;
    bl = (cur_i.bit_left != '0) ? cur_i.bit_left - 4'd1 : cur_i.bit_left;
    sb = '0;
    if (cur_i.phase != PH_IDLE) begin
      flags_o.rejected = (command_i != CMD_TICK);
      if (cur_i.hold_left != '0) begin
        n.hold_left = cur_i.hold_left - 8'd1;
      end
      if (n.hold_left == '0) begin
        unique case (cur_i.phase)
          PH_ST_REL: n = enter(n, PH_ST_SDA, lo, hi);
          PH_ST_SDA: begin
            n.bit_left = BitsPerByte;
            n = enter(n, PH_W_LOW, lo, hi);
          end
          PH_W_LOW:  n = enter(n, PH_W_DATA, lo, hi);
          PH_W_DATA: n = enter(n, PH_W_HIGH, lo, hi);
          PH_W_HIGH: begin
            n.shift_byte = {cur_i.shift_byte[ByteW-2:0], 1'b0};
            n.bit_left = bl;
            n = enter(n, (bl != '0) ? PH_W_LOW : PH_A_LOW, lo, hi);
          end
          PH_A_LOW:  n = enter(n, PH_A_REL, lo, hi);
          PH_A_REL:  n = enter(n, PH_A_HIGH, lo, hi);
          PH_A_HIGH: begin
            n.ack_flag = ~sda_in_i;
            n = finish(n);
            flags_o.done = 1'b1;
          end
          PH_R_LOW:  n = enter(n, PH_R_HIGH, lo, hi);
          PH_R_HIGH: begin
            sb = {cur_i.shift_byte[ByteW-2:0], sda_in_i};
            n.shift_byte = sb;
            n.bit_left = bl;
            if (bl != '0) begin
              n = enter(n, PH_R_LOW, lo, hi);
            end else begin
              n.last_read = sb;
              n = enter(n, PH_K_LOW, lo, hi);
            end
          end
          PH_K_LOW:  n = enter(n, PH_K_HIGH, lo, hi);
          PH_K_HIGH: begin
            n.scl_drive = 1'b0;
            n.sda_drive = 1'b1;
            n = finish(n);
            flags_o.done = 1'b1;
          end
          PH_P_LOW:  n = enter(n, PH_P_SDA, lo, hi);
          PH_P_SDA:  n = enter(n, PH_P_HIGH, lo, hi);
          PH_P_HIGH: begin
            n.sda_drive = 1'b1;
            n = finish(n);
            flags_o.done = 1'b1;
          end
          PH_IDLE: begin
            n = finish(n);
            flags_o.done = 1'b1;
          end
        endcase
      end
    end else begin
      unique case (command_i)
        CMD_START: begin
          n.active_op = OP_START;
          n.shift_byte = {address_i, read_write_i};
          n.bit_left = BitsPerByte;
          n = enter(n, PH_ST_REL, lo, hi);
        end
        CMD_WRITE: begin
          n.active_op = OP_WRITE;
          n.shift_byte = write_data_i;
          n.bit_left = BitsPerByte;
          n = enter(n, PH_W_LOW, lo, hi);
        end
        CMD_READ: begin
          n.active_op = send_ack_i ? OP_READ_ACK : OP_READ;
          n.shift_byte = '0;
          n.bit_left = BitsPerByte;
          n = enter(n, PH_R_LOW, lo, hi);
        end
        CMD_STOP: begin
          n.active_op = OP_STOP;
          n = enter(n, PH_P_LOW, lo, hi);
        end
        default: begin
          n = cur_i;
        end
      endcase
    end
    nxt_o = n;
  end

endmodule

[hw/rtl/i2c_master_bit_engine.sv]
`timescale 1ns / 1ps

// I2C master bit engine. Every input beat, a tick or a command, advances the
// sequencer by exactly one step, and one result beat comes out per input beat.
// The step is computed combinationally from the state registers and the input, so
// a new beat is taken on every clock while the output register is free or
// being drained; the output register is the only register between a beat and
// its result. The two hold registers are written through the configuration
// channel, which is always ready.
module i2c_master_bit_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] command_i,
  input  logic [6:0] address_i,
  input  logic       read_write_i,
  input  logic [7:0] write_data_i,
  input  logic       send_ack_i,
  input  logic       sda_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_level_o,
  output logic       sda_level_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic       ack_seen_o,
  output logic [7:0] read_data_o,
  output logic       rejected_o
);
  import i2cbe_pkg::*;

  eng_state_t  state_q, state_d;
  step_flags_t flags;
  logic [HoldW-1:0] low_hold_q, high_hold_q;
  logic out_valid_q;
  logic accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign accept      = in_valid_i & in_ready_o;

  i2cbe_step u_step (
    .cur_i        (state_q),
    .low_hold_i   (low_hold_q),
    .high_hold_i  (high_hold_q),
    .command_i    (command_i),
    .address_i    (address_i),
    .read_write_i (read_write_i),
    .write_data_i (write_data_i),
    .send_ack_i   (send_ack_i),
    .sda_in_i     (sda_in_i),
    .nxt_o        (state_d),
    .flags_o      (flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_hold_q  <= LowHoldReset;
      high_hold_q <= HighHoldReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LOW_HOLD:  low_hold_q  <= cfg_data_i;
        CFG_HIGH_HOLD: high_hold_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, bit_left: '0, shift_byte: '0, active_op: OP_NONE,
                   hold_left: '0, scl_drive: 1'b1, sda_drive: 1'b1, ack_flag: 1'b0,
                   last_read: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      scl_level_o <= state_d.scl_drive;
      sda_level_o <= state_d.sda_drive;
      busy_res_o  <= (state_d.phase != PH_IDLE);
      done_res_o  <= flags.done;
      ack_seen_o  <= state_d.ack_flag;
      read_data_o <= state_d.last_read;
      rejected_o  <= flags.rejected;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/i2cbe_checker.sv]
`timescale 1ns / 1ps
`include "i2c_master_bit_engine_defines.svh"

module i2cbe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       busy_res_o,
  input logic       done_res_o,
  input logic [7:0] read_data_o
);

  `I2CBE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `I2CBE_ASSERT_NEXT(a_data_hold, out_valid_o && !out_ready_i, $stable(read_data_o))
  `I2CBE_ASSERT_SAME(a_done_idle, out_valid_o && done_res_o, !busy_res_o)
  `I2CBE_ASSERT_SAME(a_ready_free, !out_valid_o, in_ready_o)

endmodule

bind i2c_master_bit_engine i2cbe_checker u_i2cbe_checker (.*);

[test/i2c_master_bit_engine_checker.sv]
`timescale 1ns / 1ps

module i2c_master_bit_engine_checker
  import i2cbe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_ready_o,
  input  logic [2:0] command_i,
  input  logic [6:0] address_i,
  input  logic       read_write_i,
  input  logic [7:0] write_data_i,
  input  logic       send_ack_i,
  input  logic       sda_in_i,
  input  logic       out_valid_o,
  input  logic       out_ready_i,
  input  logic       scl_level_o,
  input  logic       sda_level_o,
  input  logic       busy_res_o,
  input  logic       done_res_o,
  input  logic       ack_seen_o,
  input  logic [7:0] read_data_o,
  input  logic       rejected_o,
  output int         err_cnt_o,
  output int         pending_o,
  output int         results_o,
  output int         done_cnt_o,
  output int         rejected_cnt_o
);

  typedef struct packed {
    logic             scl;
    logic             sda;
    logic             busy;
    logic             done;
    logic             ack;
    logic [ByteW-1:0] rdata;
    logic             rej;
  } line_res_t;

  line_res_t line_q[$];
  line_res_t exp_line;
  line_res_t act_line;

  logic [HoldW-1:0] lo_hold;
  logic [HoldW-1:0] hi_hold;
  phase_e           ph;
  logic [3:0]       bits_left;
  logic [ByteW-1:0] shreg;
  op_e              op;
  logic [HoldW-1:0] hold_cnt;
  logic             scl_q;
  logic             sda_q;
  logic             ack_q;
  logic [ByteW-1:0] rd_q;

  function automatic logic [HoldW-1:0] eff_hold(input logic [HoldW-1:0] v);
    return (v == '0) ? HoldW'(1) : v;
  endfunction

  function automatic void enter_phase(input phase_e p);
    logic [HoldW-1:0] lo;
    logic [HoldW-1:0] hi;
    lo = eff_hold(lo_hold);
    hi = eff_hold(hi_hold);
    ph = p;
    case (p)
      PH_ST_REL: begin scl_q = 1'b1; sda_q = 1'b1; hold_cnt = hi; end
      PH_ST_SDA: begin sda_q = 1'b0; hold_cnt = hi; end
      PH_W_LOW:  begin scl_q = 1'b0; sda_q = 1'b0; hold_cnt = lo; end
      PH_W_DATA: begin sda_q = shreg[ByteW-1]; hold_cnt = ShortHold; end
      PH_W_HIGH: begin scl_q = 1'b1; hold_cnt = hi; end
      PH_A_LOW:  begin scl_q = 1'b0; hold_cnt = lo; end
      PH_A_REL:  begin sda_q = 1'b1; hold_cnt = ShortHold; end
      PH_A_HIGH: begin scl_q = 1'b1; hold_cnt = hi; end
      PH_R_LOW:  begin scl_q = 1'b0; sda_q = 1'b1; hold_cnt = lo; end
      PH_R_HIGH: begin scl_q = 1'b1; hold_cnt = hi; end
      PH_K_LOW:  begin scl_q = 1'b0; sda_q = (op != OP_READ_ACK); hold_cnt = lo; end
      PH_K_HIGH: begin scl_q = 1'b1; hold_cnt = hi; end
      PH_P_LOW:  begin scl_q = 1'b0; hold_cnt = lo; end
      PH_P_SDA:  begin sda_q = 1'b0; hold_cnt = ShortHold; end
      PH_P_HIGH: begin scl_q = 1'b1; hold_cnt = ShortHold; end
      default:   begin ph = PH_IDLE; hold_cnt = '0; end
    endcase
  endfunction

  function automatic logic close_seq();
    ph = PH_IDLE;
    op = OP_NONE;
    hold_cnt = '0;
    return 1'b1;
  endfunction

  function automatic logic end_phase(input logic sda);
    case (ph)
      PH_ST_REL: begin enter_phase(PH_ST_SDA); return 1'b0; end
      PH_ST_SDA: begin bits_left = BitsPerByte; enter_phase(PH_W_LOW); return 1'b0; end
      PH_W_LOW:  begin enter_phase(PH_W_DATA); return 1'b0; end
      PH_W_DATA: begin enter_phase(PH_W_HIGH); return 1'b0; end
      PH_W_HIGH: begin
        shreg = shreg << 1;
        if (bits_left != 4'd0) bits_left = bits_left - 4'd1;
        if (bits_left != 4'd0) enter_phase(PH_W_LOW);
        else enter_phase(PH_A_LOW);
        return 1'b0;
      end
      PH_A_LOW:  begin enter_phase(PH_A_REL); return 1'b0; end
      PH_A_REL:  begin enter_phase(PH_A_HIGH); return 1'b0; end
      PH_A_HIGH: begin ack_q = !sda; return close_seq(); end
      PH_R_LOW:  begin enter_phase(PH_R_HIGH); return 1'b0; end
      PH_R_HIGH: begin
        shreg = {shreg[ByteW-2:0], sda};
        if (bits_left != 4'd0) bits_left = bits_left - 4'd1;
        if (bits_left != 4'd0) begin
          enter_phase(PH_R_LOW);
        end else begin
          rd_q = shreg;
          enter_phase(PH_K_LOW);
        end
        return 1'b0;
      end
      PH_K_LOW:  begin enter_phase(PH_K_HIGH); return 1'b0; end
      PH_K_HIGH: begin scl_q = 1'b0; sda_q = 1'b1; return close_seq(); end
      PH_P_LOW:  begin enter_phase(PH_P_SDA); return 1'b0; end
      PH_P_SDA:  begin enter_phase(PH_P_HIGH); return 1'b0; end
      PH_P_HIGH: begin sda_q = 1'b1; return close_seq(); end
      default:   return close_seq();
    endcase
  endfunction

  function automatic line_res_t step_engine(input logic [2:0] cmd, input logic [6:0] addr,
                                            input logic rw, input logic [7:0] wd,
                                            input logic sack, input logic sda);
    logic      done_f;
    logic      rej_f;
    line_res_t r;
    done_f = 1'b0;
    rej_f = 1'b0;
    if (ph != PH_IDLE) begin
      if (cmd != CMD_TICK) rej_f = 1'b1;
      if (hold_cnt != '0) hold_cnt = hold_cnt - HoldW'(1);
      if (hold_cnt == '0) done_f = end_phase(sda);
    end else begin
      case (cmd)
        CMD_START: begin
          op = OP_START;
          shreg = {addr, rw};
          bits_left = BitsPerByte;
          enter_phase(PH_ST_REL);
        end
        CMD_WRITE: begin
          op = OP_WRITE;
          shreg = wd;
          bits_left = BitsPerByte;
          enter_phase(PH_W_LOW);
        end
        CMD_READ: begin
          if (sack) op = OP_READ_ACK;
          else op = OP_READ;
          shreg = '0;
          bits_left = BitsPerByte;
          enter_phase(PH_R_LOW);
        end
        CMD_STOP: begin
          op = OP_STOP;
          enter_phase(PH_P_LOW);
        end
        default: ;
      endcase
    end
    r = {scl_q, sda_q, (ph != PH_IDLE), done_f, ack_q, rd_q, rej_f};
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      err_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_hold = LowHoldReset;
      hi_hold = HighHoldReset;
      ph = PH_IDLE;
      bits_left = '0;
      shreg = '0;
      op = OP_NONE;
      hold_cnt = '0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      ack_q = 1'b0;
      rd_q = '0;
      line_q.delete();
      err_cnt_o = 0;
      results_o = 0;
      done_cnt_o = 0;
      rejected_cnt_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_LOW_HOLD) lo_hold = cfg_data_i;
        else hi_hold = cfg_data_i;
      end
      if (out_valid_o && out_ready_i) begin
        act_line = {scl_level_o, sda_level_o, busy_res_o, done_res_o, ack_seen_o, read_data_o,
                    rejected_o};
        results_o++;
        if (act_line.done) done_cnt_o++;
        if (act_line.rej) rejected_cnt_o++;
        if (line_q.size() == 0) begin
          $error("Result beat arrived with no command beat waiting for it.");
          err_cnt_o++;
        end else begin
          exp_line = line_q.pop_front();
          check_field("scl_level", exp_line.scl, act_line.scl);
          check_field("sda_level", exp_line.sda, act_line.sda);
          check_field("busy_res", exp_line.busy, act_line.busy);
          check_field("done_res", exp_line.done, act_line.done);
          check_field("ack_seen", exp_line.ack, act_line.ack);
          check_field("read_data", exp_line.rdata, act_line.rdata);
          check_field("rejected", exp_line.rej, act_line.rej);
        end
      end
      if (in_valid_i && in_ready_o) begin
        line_q.push_back(step_engine(command_i, address_i, read_write_i, write_data_i,
                                     send_ack_i, sda_in_i));
      end
      pending_o <= line_q.size();
    end
  end

endmodule

[test/i2c_master_bit_engine_tb.sv]
`timescale 1ns / 1ps

module i2c_master_bit_engine_tb;
  import i2cbe_pkg::*;

  localparam logic [2:0] CmdSpareLo = 3'd5;
  localparam logic [2:0] CmdSpareHi = 3'd7;
  localparam logic [7:0] HoldMin = 8'd1;
  localparam logic [7:0] HoldMax = 8'd255;
  localparam int         ItemTarget = 350;
  localparam int         PressureCycles = 400;
  localparam int         SdaRandom = 2;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic       cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [2:0] command_i;
  logic [6:0] address_i;
  logic       read_write_i;
  logic [7:0] write_data_i;
  logic       send_ack_i;
  logic       sda_in_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       scl_level_o;
  logic       sda_level_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic       ack_seen_o;
  logic [7:0] read_data_o;
  logic       rejected_o;

  int         chk_errors;
  int         chk_pending;
  int         chk_results;
  int         chk_done;
  int         chk_rejected;
  int         beats_sent;
  int         cfg_writes;
  logic [7:0] lo_cur;
  logic [7:0] hi_cur;
  bit         no_idle;
  bit         pressure_req;

  i2c_master_bit_engine u_top (.*);

  i2c_master_bit_engine_checker u_chk (
    .*,
    .err_cnt_o      (chk_errors),
    .pending_o      (chk_pending),
    .results_o      (chk_results),
    .done_cnt_o     (chk_done),
    .rejected_cnt_o (chk_rejected)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int hold_eff(input logic [7:0] v);
    return (v == 8'd0) ? 1 : int'(v);
  endfunction

  function automatic int seq_ticks(input logic [2:0] cmd);
    int lo;
    int hi;
    lo = hold_eff(lo_cur);
    hi = hold_eff(hi_cur);
    case (cmd)
      CMD_START: return 2 * hi + 9 * (lo + 1 + hi);
      CMD_WRITE: return 9 * (lo + 1 + hi);
      CMD_READ:  return 9 * (lo + hi);
      CMD_STOP:  return lo + 2;
      default:   return 0;
    endcase
  endfunction

  function automatic logic pick_sda(input int sel);
    return (sel == SdaRandom) ? 1'($urandom_range(0, 1)) : sel[0];
  endfunction

  task automatic send_beat(input logic [2:0] cmd, input logic [6:0] addr, input logic rw,
                           input logic [7:0] wd, input logic sack, input logic sda);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    address_i <= addr;
    read_write_i <= rw;
    write_data_i <= wd;
    send_ack_i <= sack;
    sda_in_i <= sda;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_noise_tick(input int sda_sel, input bit noisy);
    logic [2:0] cmd;
    cmd = CMD_TICK;
    if (noisy && $urandom_range(0, 99) < 4) cmd = 3'($urandom_range(1, 7));
    send_beat(cmd, 7'($urandom), 1'($urandom), 8'($urandom), 1'($urandom), pick_sda(sda_sel));
  endtask

  task automatic run_seq(input logic [2:0] cmd, input logic [6:0] addr, input logic rw,
                         input logic [7:0] wd, input logic sack, input int sda_sel,
                         input int extra, input bit noisy);
    int n;
    n = seq_ticks(cmd) + extra;
    if (n < 0) n = 0;
    send_beat(cmd, addr, rw, wd, sack, pick_sda(sda_sel));
    repeat (n) send_noise_tick(sda_sel, noisy);
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (chk_pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [7:0] lo, input logic [7:0] hi);
    drain_pipe();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_LOW_HOLD;
    cfg_data_i <= lo;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CFG_HIGH_HOLD;
    cfg_data_i <= hi;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    lo_cur = lo;
    hi_cur = hi;
    cfg_writes += 2;
  endtask

  function automatic logic [7:0] rand_hold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 8'($urandom_range(1, 3));
    if (r < 95) return 8'($urandom_range(4, 8));
    return 8'($urandom_range(9, 20));
  endfunction

  initial begin
    int len;
    out_ready_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (pressure_req) begin
        out_ready_i <= 1'b0;
        repeat (PressureCycles) @(posedge clk_i);
        pressure_req = 1'b0;
      end else if (no_idle) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 99) < 65) begin
        out_ready_i <= 1'b1;
        len = $urandom_range(1, 30);
        repeat (len) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        len = gap_len() + 1;
        repeat (len) @(posedge clk_i);
      end
    end
  end

  initial begin
    int         rand_start;
    int         seqs;
    int         r;
    int         extra;
    bit         pressure_fired;
    logic [2:0] cmd;

    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_LOW_HOLD;
    cfg_data_i = 8'd0;
    in_valid_i = 1'b0;
    command_i = CMD_TICK;
    address_i = 7'd0;
    read_write_i = 1'b0;
    write_data_i = 8'd0;
    send_ack_i = 1'b0;
    sda_in_i = 1'b1;
    beats_sent = 0;
    cfg_writes = 0;
    no_idle = 1'b0;
    pressure_req = 1'b0;
    pressure_fired = 1'b0;
    lo_cur = LowHoldReset;
    hi_cur = HighHoldReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset hold values: start, write and read, extreme addresses and bytes, ack and nack.
    run_seq(CMD_START, 7'h7F, 1'b1, 8'h00, 1'b0, 0, 1, 1'b0);
    run_seq(CMD_WRITE, 7'h00, 1'b0, 8'h00, 1'b0, 1, 1, 1'b0);
    run_seq(CMD_WRITE, 7'h7F, 1'b1, 8'hFF, 1'b1, 0, 1, 1'b0);
    run_seq(CMD_READ, 7'h00, 1'b0, 8'h00, 1'b1, 1, 1, 1'b0);
    run_seq(CMD_READ, 7'h00, 1'b0, 8'h00, 1'b0, 0, 1, 1'b0);
    run_seq(CMD_READ, 7'h2A, 1'b0, 8'h00, 1'b1, SdaRandom, 0, 1'b0);
    run_seq(CMD_START, 7'h00, 1'b0, 8'hA5, 1'b0, SdaRandom, 0, 1'b0);

    // Commands arriving while a stop is under way are turned away.
    send_beat(CMD_STOP, 7'h00, 1'b0, 8'h00, 1'b0, 1'b1);
    send_beat(CMD_START, 7'h55, 1'b1, 8'h00, 1'b0, 1'b0);
    send_beat(CMD_READ, 7'h00, 1'b0, 8'h00, 1'b1, 1'b1);
    send_beat(CmdSpareHi, 7'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    repeat (seq_ticks(CMD_STOP)) send_noise_tick(SdaRandom, 1'b0);

    // Unused command codes while idle act as plain ticks.
    send_beat(CmdSpareLo, 7'h7F, 1'b1, 8'hFF, 1'b1, 1'b0);
    send_beat(CmdSpareHi, 7'h00, 1'b0, 8'h00, 1'b0, 1'b1);
    send_beat(CMD_TICK, 7'h7F, 1'b1, 8'hFF, 1'b1, 1'b1);

    reconfigure(8'd0, 8'd0);
    run_seq(CMD_WRITE, 7'h00, 1'b0, 8'($urandom), 1'b0, SdaRandom, 1, 1'b0);
    run_seq(CMD_STOP, 7'h00, 1'b0, 8'h00, 1'b0, SdaRandom, 1, 1'b0);

    reconfigure(HoldMin, HoldMin);
    run_seq(CMD_START, 7'($urandom), 1'($urandom), 8'h00, 1'b0, SdaRandom, 1, 1'b0);
    run_seq(CMD_READ, 7'h00, 1'b0, 8'h00, 1'b1, SdaRandom, 1, 1'b0);
    run_seq(CMD_STOP, 7'h00, 1'b0, 8'h00, 1'b0, SdaRandom, 1, 1'b0);

    no_idle = 1'b1;
    reconfigure(HoldMax, HoldMax);
    run_seq(CMD_STOP, 7'h00, 1'b0, 8'h00, 1'b0, SdaRandom, 1, 1'b0);
    no_idle = 1'b0;

    reconfigure(rand_hold(), rand_hold());
    rand_start = beats_sent;
    seqs = 0;
    while (beats_sent < rand_start + ItemTarget) begin
      if (seqs > 0 && seqs % 5 == 0) reconfigure(rand_hold(), rand_hold());
      if (!pressure_fired && beats_sent > rand_start + 300) begin
        pressure_req = 1'b1;
        pressure_fired = 1'b1;
      end
      no_idle = (seqs % 25 >= 20 && seqs % 25 <= 22);
      r = $urandom_range(0, 99);
      if (r < 28) cmd = CMD_START;
      else if (r < 52) cmd = CMD_WRITE;
      else if (r < 76) cmd = CMD_READ;
      else if (r < 92) cmd = CMD_STOP;
      else if (r < 96) cmd = CMD_TICK;
      else cmd = 3'($urandom_range(CmdSpareLo, CmdSpareHi));
      if ($urandom_range(0, 99) < 12) extra = -$urandom_range(1, 20);
      else extra = $urandom_range(0, 3);
      run_seq(cmd, 7'($urandom), 1'($urandom), 8'($urandom), 1'($urandom), SdaRandom,
              extra, 1'b1);
      seqs++;
    end
    no_idle = 1'b0;

    drain_pipe();
    repeat (4) @(posedge clk_i);
    $display("Run covered %0d input beats and %0d result beats, with %0d finished sequences.",
             beats_sent, chk_results, chk_done);
    $display("Busy commands turned away: %0d; hold register writes: %0d, from zero to 255.",
             chk_rejected, cfg_writes);
    if (chk_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/i2cbe_pkg.sv
hw/rtl/i2cbe_step.sv
hw/rtl/i2c_master_bit_engine.sv
hw/rtl/i2cbe_checker.sv
test/i2c_master_bit_engine_checker.sv
test/i2c_master_bit_engine_tb.sv
